@@ rtl/mf_pkg.sv @@
// ----------------------------------------------------------------------------
// mf_pkg
// Shared codes and types of the 5x5 median filter.
// ----------------------------------------------------------------------------
package mf_pkg;

  // request kind carried in the mode field
  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  // configuration register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // configuration register widths
  localparam int CFG_W_BITS    = 11;
  localparam int CFG_H_BITS    = 13;
  localparam int CFG_DATA_BITS = 13;

  // per-result flags that ride along the pipeline
  typedef struct packed {
    logic interior;
    logic last;
  } side_t;

endpackage

@@ rtl/mf_if.sv @@
// ----------------------------------------------------------------------------
// mf_in_if / mf_out_if
// Valid/ready request channels of the median filter.
// ----------------------------------------------------------------------------
interface mf_in_if #(
  parameter int PB = 8
);
  logic          valid;
  logic          ready;
  logic          mode;
  logic [PB-1:0] pixel_in;

  modport source (output valid, output mode, output pixel_in, input ready);
  modport sink   (input valid, input mode, input pixel_in, output ready);
endinterface

interface mf_out_if #(
  parameter int PB = 8
);
  logic          valid;
  logic          ready;
  logic [PB-1:0] pixel_out;
  logic          last_of_image;

  modport source (output valid, output pixel_out, output last_of_image, input ready);
  modport sink   (input valid, input pixel_out, input last_of_image, output ready);
endinterface

@@ rtl/median_filter_5x5.sv @@
// ----------------------------------------------------------------------------
// median_filter_5x5
// Raster-stream 2D median filter with border pass-through and flush drain.
// ----------------------------------------------------------------------------
// Takes one request per clock when the output side keeps up, pixel or flush.
// A request passes, in order, the line buffer and hold-memory reads, the
// window update, one register per insertion cell of the sort chain
// (WINDOW_SIZE**2 - 1) and the output register. The whole pipeline holds
// while a result waits at the output. Results trail the input stream by
// HALF rows plus HALF pixels; after an image's last pixel, flush requests
// drain the remaining results.
// A configuration write restarts the stream and drops pending results.
module median_filter_5x5 #(
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_HEIGHT  = 4096,
  parameter int WINDOW_SIZE = 5,
  parameter int PIXEL_BITS  = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  mf_in_if.sink                              in_req,
  mf_out_if.source                           out_req,
  input  logic                               cfg_we,
  input  logic                               cfg_idx,
  input  logic [mf_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  localparam int PB      = PIXEL_BITS;
  localparam int HALF    = WINDOW_SIZE / 2;
  localparam int N2      = WINDOW_SIZE * WINDOW_SIZE;
  localparam int MED_IDX = N2 / 2;
  localparam int LAG_MAX = HALF * MAX_WIDTH + HALF;
  localparam int PW      = $clog2(LAG_MAX + 1);
  localparam int AW      = $clog2(LAG_MAX + 1);
  localparam int WW      = $clog2(MAX_WIDTH + 1);
  localparam int HW      = $clog2(MAX_HEIGHT + 1);
  localparam int CW      = $clog2(MAX_WIDTH);
  localparam int RW      = $clog2(MAX_HEIGHT);

  logic [mf_pkg::CFG_W_BITS-1:0] width_r;
  logic [mf_pkg::CFG_H_BITS-1:0] height_r;
  logic [WW-1:0]  w_eff;
  logic [HW-1:0]  h_eff;
  logic [PW-1:0]  lag;

  logic [RW-1:0]  in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic [CW-1:0]  in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [PW-1:0]  pending_r, pending_nxt;
  logic [AW-1:0]  wr_ptr_r, rd_ptr_r;

  logic           en, acc, is_pix, acc_pix, at_start, emit;
  mf_pkg::side_t  side_acc;

  logic           a_v_r, b_v_r, out_v_r, out_last_r;
  mf_pkg::side_t  a_side_r, b_side_r;
  logic [PB-1:0]  a_cen, b_cen_r, out_pix_r;
  logic [N2-1:0][PB-1:0] win;

  logic                  v_s    [N2];
  mf_pkg::side_t         side_s [N2];
  logic [PB-1:0]         cen_s  [N2];
  logic [N2-1:0][PB-1:0] arr_s  [N2];

  // clamped geometry and output lag
  always_comb begin
    if (width_r == '0)                 w_eff = WW'(1);
    else if (int'(width_r) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
    else                               w_eff = WW'(width_r);
    if (height_r == '0)                  h_eff = HW'(1);
    else if (int'(height_r) > MAX_HEIGHT) h_eff = HW'(MAX_HEIGHT);
    else                                 h_eff = HW'(height_r);
  end

  assign lag = PW'(HALF * int'(w_eff) + HALF);

  // handshake and emit decision
  assign en       = !out_v_r || out_req.ready;
  assign in_req.ready = en;
  assign acc      = in_req.valid && en;
  assign is_pix   = (in_req.mode == mf_pkg::MODE_PIXEL);
  assign acc_pix  = acc && is_pix;
  assign at_start = (in_row_r == '0) && (in_col_r == '0);
  assign emit     = acc && (is_pix ? (pending_r >= lag) : (at_start && pending_r != '0));

  // next positions and pending count
  always_comb begin
    in_row_nxt  = in_row_r;
    in_col_nxt  = in_col_r;
    out_row_nxt = out_row_r;
    out_col_nxt = out_col_r;
    pending_nxt = pending_r;
    if (acc_pix) begin
      if (WW'(in_col_r) == w_eff - WW'(1)) begin
        in_col_nxt = '0;
        if (HW'(in_row_r) == h_eff - HW'(1)) in_row_nxt = '0;
        else                                 in_row_nxt = in_row_r + RW'(1);
      end else begin
        in_col_nxt = in_col_r + CW'(1);
      end
      if (!emit) pending_nxt = pending_r + PW'(1);
    end else if (emit) begin
      pending_nxt = pending_r - PW'(1);
    end
    if (emit) begin
      if (WW'(out_col_r) == w_eff - WW'(1)) begin
        out_col_nxt = '0;
        if (HW'(out_row_r) == h_eff - HW'(1)) out_row_nxt = '0;
        else                                  out_row_nxt = out_row_r + RW'(1);
      end else begin
        out_col_nxt = out_col_r + CW'(1);
      end
    end
  end

  // border test and end-of-image flag of the pixel going out
  always_comb begin
    side_acc.interior = (int'(out_row_r) >= HALF) && (int'(out_row_r) + HALF < int'(h_eff))
                     && (int'(out_col_r) >= HALF) && (int'(out_col_r) + HALF < int'(w_eff));
    side_acc.last     = (HW'(out_row_r) == h_eff - HW'(1)) && (WW'(out_col_r) == w_eff - WW'(1));
  end

  // configuration registers and stream position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= mf_pkg::CFG_W_BITS'(1024);
      height_r  <= mf_pkg::CFG_H_BITS'(4096);
      in_row_r  <= '0;
      in_col_r  <= '0;
      out_row_r <= '0;
      out_col_r <= '0;
      pending_r <= '0;
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        mf_pkg::REG_WIDTH:  width_r  <= cfg_data[mf_pkg::CFG_W_BITS-1:0];
        mf_pkg::REG_HEIGHT: height_r <= cfg_data[mf_pkg::CFG_H_BITS-1:0];
        default: ;
      endcase
      in_row_r  <= '0;
      in_col_r  <= '0;
      out_row_r <= '0;
      out_col_r <= '0;
      pending_r <= '0;
      rd_ptr_r  <= wr_ptr_r;
    end else begin
      in_row_r  <= in_row_nxt;
      in_col_r  <= in_col_nxt;
      out_row_r <= out_row_nxt;
      out_col_r <= out_col_nxt;
      pending_r <= pending_nxt;
      if (acc_pix) wr_ptr_r <= wr_ptr_r + AW'(1);
      if (emit)    rd_ptr_r <= rd_ptr_r + AW'(1);
    end
  end

  // pixels waiting for output, used on the border
  mf_ram #(.AW(AW), .PB(PB)) u_hold (
    .clk   (clk),
    .we    (acc_pix),
    .waddr (wr_ptr_r),
    .wdata (in_req.pixel_in),
    .re    (emit),
    .raddr (rd_ptr_r),
    .rdata (a_cen)
  );

  // line buffers and window
  mf_window #(.N(WINDOW_SIZE), .PB(PB), .DEPTH(MAX_WIDTH), .CW(CW)) u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .acc_pix (acc_pix),
    .col     (in_col_r),
    .pix     (in_req.pixel_in),
    .win     (win)
  );

  // read and window stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= emit;
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_side_r <= side_acc;
      b_side_r <= a_side_r;
      b_cen_r  <= a_cen;
    end
  end

  // insertion sort chain
  assign v_s[0]    = b_v_r;
  assign side_s[0] = b_side_r;
  assign cen_s[0]  = b_cen_r;
  assign arr_s[0]  = win;

  for (genvar k = 1; k < N2; k++) begin : g_cell
    mf_sort_cell #(.N2(N2), .PB(PB), .K(k)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .v_in    (v_s[k-1]),
      .side_in (side_s[k-1]),
      .cen_in  (cen_s[k-1]),
      .arr_in  (arr_s[k-1]),
      .v_r     (v_s[k]),
      .side_r  (side_s[k]),
      .cen_r   (cen_s[k]),
      .arr_r   (arr_s[k])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= v_s[N2-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_pix_r  <= side_s[N2-1].interior ? arr_s[N2-1][MED_IDX] : cen_s[N2-1];
      out_last_r <= side_s[N2-1].last;
    end
  end

  assign out_req.valid         = out_v_r;
  assign out_req.pixel_out     = out_pix_r;
  assign out_req.last_of_image = out_last_r;

  // pending results never exceed the lag
  a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r <= lag)
    else $error("pending count above lag");

  // hold memory occupancy matches the pending count
  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r - rd_ptr_r) == AW'(pending_r))
    else $error("hold memory pointers out of step with pending count");

  // configuration write restarts the stream
  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> (pending_r == '0 && in_row_r == '0 && in_col_r == '0 && out_col_r == '0))
    else $error("stream not restarted after configuration write");

endmodule

@@ rtl/mf_ram.sv @@
// ----------------------------------------------------------------------------
// mf_ram
// Simple dual-port memory with registered read, holds pixels awaiting output.
// ----------------------------------------------------------------------------
module mf_ram #(
  parameter int AW = 12,
  parameter int PB = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [PB-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [PB-1:0] rdata
);

  logic [PB-1:0] mem [2**AW];
  logic [PB-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // read port
  always_ff @(posedge clk) begin
    if (re) rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/mf_window.sv @@
// ----------------------------------------------------------------------------
// mf_window
// Line buffers and the sliding NxN window over the input pixel stream.
// ----------------------------------------------------------------------------
module mf_window #(
  parameter int N     = 5,
  parameter int PB    = 8,
  parameter int DEPTH = 1024,
  parameter int CW    = 10
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    acc_pix,
  input  logic [CW-1:0]           col,
  input  logic [PB-1:0]           pix,
  output logic [N*N-1:0][PB-1:0]  win
);

  logic                         wr_a_r;
  logic [CW-1:0]                col_a_r;
  logic [PB-1:0]                pix_a_r;
  logic [PB-1:0]                rd_r  [N-1];
  logic [PB-1:0]                wdata [N-1];
  logic [PB-1:0]                col_new [N];
  logic [N-1:0][N-1:0][PB-1:0]  win_r;

  // pixel stage that follows acceptance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_a_r <= 1'b0;
    end else if (en) begin
      wr_a_r <= acc_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_pix) begin
      col_a_r <= col;
      pix_a_r <= pix;
    end
  end

  // chained line buffers, each one row older than the last
  for (genvar k = 0; k < N-1; k++) begin : g_lbuf
    logic [PB-1:0] mem [DEPTH];

    if (k == 0) begin : g_first
      assign wdata[k] = pix_a_r;
    end else begin : g_next
      assign wdata[k] = rd_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (en && wr_a_r) mem[col_a_r] <= wdata[k];
      // forward a write to the same column (one-pixel-wide rows)
      if (acc_pix) begin
        rd_r[k] <= (wr_a_r && (col_a_r == col)) ? wdata[k] : mem[col];
      end
    end
  end

  // new right-hand column, oldest row on top
  always_comb begin
    for (int r = 0; r < N; r++) begin
      if (r == N-1) col_new[r] = pix_a_r;
      else          col_new[r] = rd_r[N-2-r];
    end
  end

  // window shifts left by one column per pixel
  always_ff @(posedge clk) begin
    if (en && wr_a_r) begin
      for (int r = 0; r < N; r++) begin
        for (int c = 0; c < N-1; c++) begin
          win_r[r][c] <= win_r[r][c+1];
        end
        win_r[r][N-1] <= col_new[r];
      end
    end
  end

  assign win = win_r;

endmodule

@@ rtl/mf_sort_cell.sv @@
// ----------------------------------------------------------------------------
// mf_sort_cell
// One insertion step: places element K into the sorted prefix of K values.
// ----------------------------------------------------------------------------
module mf_sort_cell #(
  parameter int N2 = 25,
  parameter int PB = 8,
  parameter int K  = 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   v_in,
  input  mf_pkg::side_t          side_in,
  input  logic [PB-1:0]          cen_in,
  input  logic [N2-1:0][PB-1:0]  arr_in,
  output logic                   v_r,
  output mf_pkg::side_t          side_r,
  output logic [PB-1:0]          cen_r,
  output logic [N2-1:0][PB-1:0]  arr_r
);

  logic [PB-1:0]         val;
  logic [N2-1:0][PB-1:0] arr_nxt;

  assign val = arr_in[K];

  // each slot of the prefix picks itself, the new value or its left neighbor
  always_comb begin
    for (int j = 0; j < N2; j++) begin
      if (j > K) begin
        arr_nxt[j] = arr_in[j];
      end else if (j < K && arr_in[j] <= val) begin
        arr_nxt[j] = arr_in[j];
      end else if (j == 0) begin
        arr_nxt[j] = val;
      end else if (arr_in[j-1] <= val) begin
        arr_nxt[j] = val;
      end else begin
        arr_nxt[j] = arr_in[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= side_in;
      cen_r  <= cen_in;
      arr_r  <= arr_nxt;
    end
  end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 5x5 median filter: a queue-fed driver sends
// pixel and flush requests under random idling, a line-store predictor works
// out the filtered stream, and a monitor checks every result in order.
// ----------------------------------------------------------------------------
module testbench;

  localparam int MAXW      = 1024;
  localparam int MAXH      = 4096;
  localparam int HALF      = 2;
  localparam int DEPTH     = 2 * (HALF * MAXW + HALF) + 1;
  localparam int SETTLE    = 40;
  localparam int WD_LIMIT  = 4000;
  localparam int HOLD_LEN  = 400;
  localparam int CALM_LEFT = 200;

  typedef enum logic [1:0] {ENT_REQ, ENT_CFG, ENT_DRAIN} entry_kind_t;

  typedef struct {
    entry_kind_t kind;
    logic        mode;
    logic [7:0]  pixel;
    logic        idx;
    logic [mf_pkg::CFG_DATA_BITS-1:0] data;
  } entry_t;

  typedef struct {
    logic [7:0] pixel;
    logic       last;
  } result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_idx;
  logic [mf_pkg::CFG_DATA_BITS-1:0] cfg_data;

  mf_in_if  #(.PB(8)) in_bus ();
  mf_out_if #(.PB(8)) out_bus ();

  median_filter_5x5 u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_bus),
    .out_req (out_bus),
    .cfg_we  (cfg_we),
    .cfg_idx (cfg_idx),
    .cfg_data(cfg_data)
  );

  entry_t  request_q[$];
  result_t median_expect_q[$];
  int      error_count = 0;
  int      quiet_cycles = 0;
  int      idle_cycles = 0;
  int      stall_cycles = 0;
  int      hold_cycles = 0;
  int      rand_pixels = 0;
  bit      hold_done = 0;
  int      wd_count = 0;

  // predictor state
  logic [7:0]  line_store[DEPTH];
  logic [10:0] reg_width = 11'd1024;
  logic [12:0] reg_height = 13'd4096;
  int pr_wr = 0, pr_pending = 0;
  int pr_in_row = 0, pr_in_col = 0, pr_out_row = 0, pr_out_col = 0;

  function automatic int width_used();
    if (reg_width < 1) return 1;
    if (reg_width > MAXW) return MAXW;
    return int'(reg_width);
  endfunction

  function automatic int height_used();
    if (reg_height < 1) return 1;
    if (reg_height > MAXH) return MAXH;
    return int'(reg_height);
  endfunction

  // oldest pending pixel: window median inside, copy on the border
  function automatic void filter_emit(int w, int h);
    int base, idx, k, t;
    logic [7:0] win[25];
    logic [7:0] v;
    result_t r;
    base = (pr_wr + DEPTH - pr_pending) % DEPTH;
    if (pr_out_row >= HALF && pr_out_row + HALF < h &&
        pr_out_col >= HALF && pr_out_col + HALF < w) begin
      k = 0;
      for (int dr = -HALF; dr <= HALF; dr++) begin
        for (int dc = -HALF; dc <= HALF; dc++) begin
          idx = ((base + dr * w + dc) % DEPTH + DEPTH) % DEPTH;
          win[k] = line_store[idx];
          k++;
        end
      end
      for (int i = 1; i < 25; i++) begin
        v = win[i];
        t = i - 1;
        while (t >= 0 && win[t] > v) begin
          win[t + 1] = win[t];
          t--;
        end
        win[t + 1] = v;
      end
      r.pixel = win[12];
    end else begin
      r.pixel = line_store[base];
    end
    r.last = (pr_out_row == h - 1 && pr_out_col == w - 1);
    median_expect_q.insert(median_expect_q.size(), r);
    pr_out_col++;
    if (pr_out_col >= w) begin
      pr_out_col = 0;
      pr_out_row++;
      if (pr_out_row >= h) pr_out_row = 0;
    end
    pr_pending--;
  endfunction

  function automatic void filter_predict(logic mode, logic [7:0] pixel);
    int w, h;
    w = width_used();
    h = height_used();
    if (mode == mf_pkg::MODE_PIXEL) begin
      line_store[pr_wr] = pixel;
      pr_wr = (pr_wr + 1) % DEPTH;
      pr_pending++;
      pr_in_col++;
      if (pr_in_col >= w) begin
        pr_in_col = 0;
        pr_in_row++;
        if (pr_in_row >= h) pr_in_row = 0;
      end
      if (pr_pending > HALF * w + HALF) filter_emit(w, h);
    end else if (pr_in_row == 0 && pr_in_col == 0 && pr_pending > 0) begin
      filter_emit(w, h);
    end
  endfunction

  function automatic void filter_config(logic idx, logic [mf_pkg::CFG_DATA_BITS-1:0] data);
    if (idx == mf_pkg::REG_WIDTH) reg_width = data[10:0];
    else reg_height = data[12:0];
    pr_in_row = 0; pr_in_col = 0; pr_out_row = 0; pr_out_col = 0;
    pr_pending = 0;
  endfunction

  // stimulus builders
  function automatic void push_cfg(logic idx, int data);
    entry_t e;
    e.kind = ENT_CFG; e.idx = idx; e.data = mf_pkg::CFG_DATA_BITS'(data);
    e.mode = mf_pkg::MODE_PIXEL; e.pixel = '0;
    request_q.insert(request_q.size(), e);
  endfunction

  function automatic void push_req(logic mode, logic [7:0] pixel);
    entry_t e;
    e.kind = ENT_REQ; e.mode = mode; e.pixel = pixel; e.idx = '0; e.data = '0;
    request_q.insert(request_q.size(), e);
  endfunction

  function automatic void push_drain();
    entry_t e;
    e.kind = ENT_DRAIN; e.mode = mf_pkg::MODE_PIXEL; e.pixel = '0; e.idx = '0; e.data = '0;
    request_q.insert(request_q.size(), e);
  endfunction

  function automatic logic [7:0] rand_pixel();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // one image; a stray flush inside it drains a result only at the start of an image
  function automatic int push_image(int w, int h, bit noise);
    for (int i = 0; i < w * h; i++) begin
      if (noise && $urandom_range(0, 19) == 0) push_req(mf_pkg::MODE_FLUSH, rand_pixel());
      push_req(mf_pkg::MODE_PIXEL, rand_pixel());
    end
    return w * h;
  endfunction

  function automatic void push_flush(int w, int extra);
    for (int i = 0; i < HALF * w + HALF + extra; i++) push_req(mf_pkg::MODE_FLUSH, rand_pixel());
  endfunction

  function automatic void idle_cycles_wd(bit idle);
    if (idle) wd_count++;
    else wd_count = 0;
  endfunction

  // clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // driver
  always @(posedge clk) begin
    automatic bit offering;
    automatic bit we_nxt;
    automatic entry_t e;
    if (!rst_n) begin
      in_bus.valid    <= 1'b0;
      in_bus.mode     <= mf_pkg::MODE_PIXEL;
      in_bus.pixel_in <= '0;
      cfg_we          <= 1'b0;
      cfg_idx         <= mf_pkg::REG_WIDTH;
      cfg_data        <= '0;
    end else begin
      offering = in_bus.valid;
      we_nxt = 1'b0;
      if (in_bus.valid && in_bus.ready) begin
        filter_predict(in_bus.mode, in_bus.pixel_in);
        offering = 1'b0;
      end
      if (!offering) begin
        if (idle_cycles > 0) begin
          idle_cycles--;
          in_bus.valid <= 1'b0;
        end else if (request_q.size() == 0) begin
          in_bus.valid <= 1'b0;
        end else begin
          e = request_q[0];
          case (e.kind)
            ENT_REQ: begin
              void'(request_q.pop_front());
              in_bus.valid    <= 1'b1;
              in_bus.mode     <= e.mode;
              in_bus.pixel_in <= e.pixel;
              if (request_q.size() > CALM_LEFT && $urandom_range(0, 7) == 0)
                idle_cycles = $urandom_range(1, 8);
            end
            ENT_CFG: begin
              in_bus.valid <= 1'b0;
              if (median_expect_q.size() == 0 && quiet_cycles >= SETTLE) begin
                void'(request_q.pop_front());
                we_nxt = 1'b1;
                cfg_idx  <= e.idx;
                cfg_data <= e.data;
                filter_config(e.idx, e.data);
              end
            end
            default: begin
              in_bus.valid <= 1'b0;
              if (median_expect_q.size() == 0) void'(request_q.pop_front());
            end
          endcase
        end
      end
      cfg_we <= we_nxt;
    end
  end

  // monitor and result check
  always @(posedge clk) begin
    automatic result_t r;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      stall_cycles = 0;
      hold_cycles = 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (median_expect_q.size() == 0) begin
          $error("unexpected result: pixel_out %0d", out_bus.pixel_out);
          error_count++;
        end else begin
          r = median_expect_q.pop_front();
          if (out_bus.pixel_out !== r.pixel) begin
            $error("pixel_out expected %0d actual %0d", r.pixel, out_bus.pixel_out);
            error_count++;
          end
          if (out_bus.last_of_image !== r.last) begin
            $error("last_of_image expected %0d actual %0d", r.last, out_bus.last_of_image);
            error_count++;
          end
        end
      end
      // one long hold-off so the pipeline fills and stalls the input
      if (!hold_done && rand_pixels > 0 && median_expect_q.size() > 12) begin
        hold_done = 1;
        hold_cycles = HOLD_LEN;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_bus.ready <= 1'b0;
      end else if (stall_cycles > 0) begin
        stall_cycles--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
        if (request_q.size() > CALM_LEFT && $urandom_range(0, 7) == 0)
          stall_cycles = $urandom_range(1, 8);
      end
    end
  end

  // activity tracking and watchdog
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) || cfg_we) begin
      quiet_cycles <= 0;
      if (in_bus.valid && in_bus.ready || out_bus.valid && out_bus.ready) idle_cycles_wd(0);
      else idle_cycles_wd(1);
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      idle_cycles_wd(1);
    end
  end

  always @(posedge clk) begin
    if (wd_count >= WD_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    automatic int n, wr, hr;
    rst_n = 1'b0;
    // directed: one-pixel images at both pixel extremes, clamped zero sizes
    push_cfg(mf_pkg::REG_WIDTH, 1);
    push_cfg(mf_pkg::REG_HEIGHT, 1);
    push_req(mf_pkg::MODE_PIXEL, 8'd0);
    push_req(mf_pkg::MODE_PIXEL, 8'd255);
    push_flush(1, 1);
    push_cfg(mf_pkg::REG_WIDTH, 0);
    push_cfg(mf_pkg::REG_HEIGHT, 0);
    push_req(mf_pkg::MODE_FLUSH, 8'd0);
    push_req(mf_pkg::MODE_PIXEL, 8'd170);
    push_flush(1, 0);
    // directed: smallest image with one interior pixel
    push_cfg(mf_pkg::REG_WIDTH, 5);
    push_cfg(mf_pkg::REG_HEIGHT, 5);
    for (int i = 0; i < 25; i++) push_req(mf_pkg::MODE_PIXEL, (i % 2) ? 8'd255 : 8'd0);
    push_flush(5, 0);
    rand_pixels = 0;
    // random phases
    while (rand_pixels < 450) begin
      wr = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 16);
      hr = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 10);
      push_cfg(mf_pkg::REG_WIDTH, wr | ($urandom_range(0, 3) << 11));
      push_cfg(mf_pkg::REG_HEIGHT, hr);
      n = $urandom_range(1, 3);
      for (int k = 0; k < n; k++) begin
        rand_pixels += push_image(wr, hr, 1);
        if (k == n - 1 || $urandom_range(0, 1)) push_flush(wr, $urandom_range(0, 3));
        if ($urandom_range(0, 5) == 0) push_drain();
      end
    end
    // widest row, clamped from an out-of-range register value; first results drained
    push_cfg(mf_pkg::REG_WIDTH, 2047);
    push_cfg(mf_pkg::REG_HEIGHT, 1);
    void'(push_image(MAXW, 1, 0));
    for (int i = 0; i < 3; i++) push_req(mf_pkg::MODE_FLUSH, rand_pixel());
    // tallest image, clamped; only the top rows are sent before the restart
    push_cfg(mf_pkg::REG_WIDTH, 5);
    push_cfg(mf_pkg::REG_HEIGHT, 8191);
    void'(push_image(5, 3, 0));
    push_cfg(mf_pkg::REG_WIDTH, 7);
    push_cfg(mf_pkg::REG_HEIGHT, 6);
    void'(push_image(7, 6, 0));
    push_flush(7, 0);
    rand_pixels = 1;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (request_q.size() != 0 || in_bus.valid) @(posedge clk);
    while (median_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/mf_pkg.sv
rtl/mf_if.sv
rtl/mf_ram.sv
rtl/mf_window.sv
rtl/mf_sort_cell.sv
rtl/median_filter_5x5.sv
tb/sv/testbench.sv
